// ===== design/sbpn_pkg.sv =====
package sbpn_pkg;

  localparam int unsigned NumBandsDefault = 16;

  localparam int unsigned BandW   = 4;
  localparam int unsigned MagW    = 15;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned DecayW  = 16;
  localparam int unsigned FracW   = 8;
  localparam int unsigned PeakW   = 24;
  localparam int unsigned IntW    = PeakW - FracW;
  localparam int unsigned DvdW    = MagW + FracW;
  localparam int unsigned DivSteps = LevelW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] LevelMax = '1;

  localparam logic [MagW-1:0]   OffsetBand0Rst  = MagW'(100);
  localparam logic [MagW-1:0]   OffsetBand1Rst  = MagW'(50);
  localparam logic [MagW-1:0]   OffsetBand2Rst  = MagW'(15);
  localparam logic [MagW-1:0]   OffsetBand3Rst  = MagW'(10);
  localparam logic [MagW-1:0]   OffsetOtherRst  = MagW'(3);
  localparam logic [DecayW-1:0] DecayFactorRst  = DecayW'(63570);
  localparam logic [MagW-1:0]   PeakFloorRst    = MagW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CfgOffsetBand0 = 3'd0,
    CfgOffsetBand1 = 3'd1,
    CfgOffsetBand2 = 3'd2,
    CfgOffsetBand3 = 3'd3,
    CfgOffsetOther = 3'd4,
    CfgDecayFactor = 3'd5,
    CfgPeakFloor   = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [BandW-1:0] band_index;
    logic [MagW-1:0]  magnitude;
  } in_word_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              peak_hit;
    logic              pair_valid;
    logic [LevelW-1:0] pair_average;
  } out_word_t;

  typedef struct packed {
    logic [MagW-1:0]   offset_band0;
    logic [MagW-1:0]   offset_band1;
    logic [MagW-1:0]   offset_band2;
    logic [MagW-1:0]   offset_band3;
    logic [MagW-1:0]   offset_other;
    logic [DecayW-1:0] decay_factor;
    logic [MagW-1:0]   peak_floor;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMul,
    StMax,
    StDiv,
    StFinish
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic peak_upd;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic band_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/sbpn_cfg.sv =====
module sbpn_cfg
  import sbpn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgOffsetBand0: cfg_d.offset_band0 = cfg_data_i[MagW-1:0];
        CfgOffsetBand1: cfg_d.offset_band1 = cfg_data_i[MagW-1:0];
        CfgOffsetBand2: cfg_d.offset_band2 = cfg_data_i[MagW-1:0];
        CfgOffsetBand3: cfg_d.offset_band3 = cfg_data_i[MagW-1:0];
        CfgOffsetOther: cfg_d.offset_other = cfg_data_i[MagW-1:0];
        CfgDecayFactor: cfg_d.decay_factor = cfg_data_i[DecayW-1:0];
        CfgPeakFloor:   cfg_d.peak_floor   = cfg_data_i[MagW-1:0];
        // unknown index: drop the word
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_band0 <= OffsetBand0Rst;
      cfg_q.offset_band1 <= OffsetBand1Rst;
      cfg_q.offset_band2 <= OffsetBand2Rst;
      cfg_q.offset_band3 <= OffsetBand3Rst;
      cfg_q.offset_other <= OffsetOtherRst;
      cfg_q.decay_factor <= DecayFactorRst;
      cfg_q.peak_floor   <= PeakFloorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/sbpn_ctrl.sv =====
module sbpn_ctrl
  import sbpn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic div_last;

  assign div_last = (cnt_q == DivCntW'(DivSteps - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StRead;
      end
      StRead: begin
        state_d = status_i.band_ok ? StMul : StFinish;
      end
      StMul: begin
        state_d = StMax;
      end
      StMax: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + DivCntW'(1);
        if (div_last) state_d = StFinish;
      end
      StFinish: begin
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StRead:   cmd_o = '0;
      StMul:    cmd_o.mul      = 1'b1;
      StMax:    cmd_o.peak_upd = 1'b1;
      StDiv:    cmd_o.div_step = 1'b1;
      StFinish: cmd_o.finish   = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/sbpn_dp.sv =====
module sbpn_dp
  import sbpn_pkg::*;
#(
  parameter int unsigned NumBands = NumBandsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  in_word_t   in_word_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_word_t  out_word_o
);

  localparam int unsigned AddrW = $clog2(NumBands);
  localparam int unsigned RemW  = IntW;

  // peak store, one valid bit per band stands for the zero reset
  logic [PeakW-1:0]    peak_mem_q [NumBands];
  logic [NumBands-1:0] peak_vld_q;

  logic [BandW-1:0]  band_q;
  logic [AddrW-1:0]  addr_q;
  logic              ok_q;
  logic [MagW-1:0]   n_q;
  logic [PeakW-1:0]  rd_q;
  logic              rd_vld_q;
  logic [PeakW-1:0]  decayed_q;
  logic              hit_q;
  logic              ip_zero_q;
  logic [IntW-1:0]   divisor_q;
  logic [RemW-1:0]   rem_q;
  logic [LevelW-1:0] dlow_q;
  logic [LevelW-1:0] quot_q;
  logic [LevelW-1:0] prev_level_q;
  logic              out_vld_q;
  out_word_t         out_q;

  logic              in_ok;
  logic [AddrW-1:0]  in_addr;
  logic [MagW-1:0]   offset;
  logic [MagW-1:0]   n_in;
  logic [PeakW-1:0]  peak_old;
  logic [PeakW+DecayW-1:0] prod;
  logic [PeakW-1:0]  n_fx;
  logic [PeakW-1:0]  fl_fx;
  logic [PeakW-1:0]  peak_new;
  logic [DvdW-1:0]   dividend;
  logic [RemW:0]     trial;
  logic [LevelW-1:0] level;
  logic [LevelW:0]   pair_sum;
  out_word_t         result;

  assign in_ok   = (32'(in_word_i.band_index) < NumBands);
  assign in_addr = AddrW'(in_word_i.band_index);

  always_comb begin
    case (in_word_i.band_index)
      BandW'(0): offset = cfg_i.offset_band0;
      BandW'(1): offset = cfg_i.offset_band1;
      BandW'(2): offset = cfg_i.offset_band2;
      BandW'(3): offset = cfg_i.offset_band3;
      default:   offset = cfg_i.offset_other;
    endcase
  end

  assign n_in = (in_word_i.magnitude > offset) ? (in_word_i.magnitude - offset) : '0;

  assign peak_old = rd_vld_q ? rd_q : '0;
  assign prod     = peak_old * cfg_i.decay_factor;

  assign n_fx  = PeakW'({n_q, FracW'(0)});
  assign fl_fx = PeakW'({cfg_i.peak_floor, FracW'(0)});

  always_comb begin
    peak_new = decayed_q;
    if (n_fx > peak_new)  peak_new = n_fx;
    if (fl_fx > peak_new) peak_new = fl_fx;
  end

  // n*255 as (n << 8) - n; the quotient fits in eight bits since peak >= n << 8
  assign dividend = {n_q, FracW'(0)} - DvdW'(n_q);
  assign trial    = {rem_q, dlow_q[LevelW-1]};

  assign level = ip_zero_q ? ((n_q != '0) ? LevelMax : '0) : quot_q;
  assign pair_sum = {1'b0, level} + {1'b0, prev_level_q};

  always_comb begin
    result = '0;
    if (ok_q) begin
      result.level      = level;
      result.peak_hit   = hit_q;
      result.pair_valid = band_q[0];
      if (band_q[0]) result.pair_average = pair_sum[LevelW:1];
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      band_q <= in_word_i.band_index;
      addr_q <= in_addr;
      n_q    <= n_in;
      if (in_ok) begin
        rd_q <= peak_mem_q[in_addr];
      end
    end
    if (cmd_i.mul) begin
      decayed_q <= prod[PeakW+DecayW-1:DecayW];
    end
    if (cmd_i.peak_upd) begin
      peak_mem_q[addr_q] <= peak_new;
      hit_q     <= (peak_new == n_fx);
      ip_zero_q <= (peak_new[PeakW-1:FracW] == '0);
      divisor_q <= peak_new[PeakW-1:FracW];
      rem_q     <= RemW'(dividend[DvdW-1:LevelW]);
      dlow_q    <= dividend[LevelW-1:0];
      quot_q    <= '0;
    end
    if (cmd_i.div_step) begin
      dlow_q <= {dlow_q[LevelW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        rem_q  <= RemW'(trial - {1'b0, divisor_q});
        quot_q <= {quot_q[LevelW-2:0], 1'b1};
      end else begin
        rem_q  <= trial[RemW-1:0];
        quot_q <= {quot_q[LevelW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q         <= 1'b0;
      rd_vld_q     <= 1'b0;
      peak_vld_q   <= '0;
      prev_level_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        ok_q     <= in_ok;
        rd_vld_q <= in_ok && peak_vld_q[in_addr];
      end
      if (cmd_i.peak_upd) begin
        peak_vld_q[addr_q] <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_vld_q <= 1'b1;
        if (ok_q) prev_level_q <= level;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o.band_ok  = ok_q;
  assign status_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o       = out_vld_q;
  assign out_word_o        = out_q;

endmodule

// ===== design/spectrum_band_peak_normalizer.sv =====
// Spectrum band peak normalizer.
// Input channel (in_valid_i/in_ready_o, in_word_i): one band magnitude and its
// band index per word. Output channel (out_valid_o/out_ready_i, out_word_o):
// one result word per input word, in order: level against the band's decaying
// peak, peak hit flag, and on odd bands the average with the previous level.
// Configuration channel (cfg_valid_i/cfg_ready_o): register index and data,
// always ready; write only while no word is in flight.
// Each word passes the accept step, which reads the band's peak, a band check
// step and, for bands in range, a multiply step, the peak update and an 8-step
// restoring divider that produces one level bit per cycle; a band index beyond
// the band count skips to the finish step (all-zero result). The finish step
// registers the result; only then is the next word accepted.
// A finished result sits in an output register; the next word is accepted
// while it waits. If the receiver stalls, the following result holds in the
// finish step until the output register frees up, and input ready stays low.
// Reset restores the register defaults, clears the band peaks (through
// per-band valid bits, no clearing pass) and the previous level.
module spectrum_band_peak_normalizer
  import sbpn_pkg::*;
#(
  parameter int unsigned NumBands = NumBandsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  sbpn_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sbpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbpn_dp #(
    .NumBands (NumBands)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== design/sbpn_checker.sv =====
module sbpn_checker
  import sbpn_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed or dropped");

  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

  // a new peak set by the magnitude gives full scale, or zero on an empty band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.peak_hit |->
      out_word_o.level == LevelMax || out_word_o.level == '0)
    else $error("peak hit with partial level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.pair_valid |-> out_word_o.pair_average == '0)
    else $error("pair average set on even band");

endmodule

bind spectrum_band_peak_normalizer sbpn_checker u_sbpn_checker (.*);

// ===== test/tb.sv =====
module tb
  import sbpn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBands = NumBandsDefault;
  localparam logic [CfgIdxW-1:0] CfgUnusedIndex = 3'd7;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LongHoldCycles = 300;

  typedef enum int unsigned {
    RxFree,
    RxCoin,
    RxSparse
  } rx_mode_e;

  // Tracks per-band decaying peaks and predicts the level word for each band word.
  class peak_level_tracker;
    logic [MagW-1:0]   band_offset [5];
    logic [DecayW-1:0] decay;
    logic [MagW-1:0]   floor_level;
    logic [PeakW-1:0]  band_peak [NumBands];
    logic [LevelW-1:0] last_level;
    out_word_t         expected_levels [$];
    int unsigned       errors;

    function new();
      band_offset[0] = OffsetBand0Rst;
      band_offset[1] = OffsetBand1Rst;
      band_offset[2] = OffsetBand2Rst;
      band_offset[3] = OffsetBand3Rst;
      band_offset[4] = OffsetOtherRst;
      decay = DecayFactorRst;
      floor_level = PeakFloorRst;
      foreach (band_peak[i]) band_peak[i] = '0;
      last_level = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx) inside
        CfgOffsetBand0, CfgOffsetBand1, CfgOffsetBand2, CfgOffsetBand3,
        CfgOffsetOther: band_offset[idx] = data[MagW-1:0];
        CfgDecayFactor: decay = data[DecayW-1:0];
        CfgPeakFloor:   floor_level = data[MagW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    endfunction

    function void note_band_word(in_word_t w);
      out_word_t                exp;
      logic [MagW-1:0]          off;
      logic [MagW-1:0]          n;
      logic [PeakW+DecayW-1:0]  prod;
      logic [PeakW-1:0]         peak;
      logic [PeakW-1:0]         n_fx;
      logic [PeakW-1:0]         floor_fx;
      logic [IntW-1:0]          whole;
      int unsigned              quot;
      int unsigned              b;
      exp = '0;
      b = 32'(w.band_index);
      if (b >= NumBands) begin
        expected_levels.push_back(exp);
        return;
      end
      off = band_offset[(b < 4) ? b : 4];
      n = (w.magnitude > off) ? w.magnitude - off : '0;
      prod = band_peak[b] * decay;
      peak = prod[PeakW+DecayW-1:DecayW];
      n_fx = {n, {FracW{1'b0}}};
      floor_fx = {floor_level, {FracW{1'b0}}};
      if (n_fx > peak) peak = n_fx;
      if (floor_fx > peak) peak = floor_fx;
      band_peak[b] = peak;
      whole = peak[PeakW-1:FracW];
      if (whole == '0) begin
        exp.level = (n != '0) ? LevelMax : '0;
      end else begin
        quot = (n * LevelMax) / whole;
        exp.level = (quot > LevelMax) ? LevelMax : LevelW'(quot);
      end
      exp.peak_hit = (peak == n_fx);
      if (b[0]) begin
        exp.pair_valid = 1'b1;
        exp.pair_average = LevelW'(({1'b0, exp.level} + {1'b0, last_level}) >> 1);
      end
      last_level = exp.level;
      expected_levels.push_back(exp);
    endfunction

    function void compare_field(string name, logic [LevelW-1:0] want,
                                logic [LevelW-1:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_level_word(out_word_t got);
      out_word_t exp;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got level %0d",
                 $time, got.level);
        errors++;
        return;
      end
      exp = expected_levels.pop_front();
      compare_field("level", exp.level, got.level);
      compare_field("peak_hit", exp.peak_hit, got.peak_hit);
      compare_field("pair_valid", exp.pair_valid, got.pair_valid);
      compare_field("pair_average", exp.pair_average, got.pair_average);
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  peak_level_tracker tracker = new();
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;

  spectrum_band_peak_normalizer #(
    .NumBands(NumBands)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
    if (in_valid && in_ready) tracker.note_band_word(in_word);
    if (out_valid && out_ready) begin
      tracker.check_level_word(out_word);
      results_seen++;
    end
  end

  // Receiver: stall patterns that change now and then, plus long hold-offs
  // that back the block up into its input.
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned next_hold_at;
    mode = RxFree;
    mode_left = 0;
    hold_left = 0;
    next_hold_at = 100;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (results_seen >= next_hold_at) begin
        out_ready = 1'b0;
        hold_left = LongHoldCycles;
        next_hold_at += 350;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(RxFree, RxSparse));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RxFree:  out_ready = 1'b1;
          RxCoin:  out_ready = 1'($urandom_range(0, 1));
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic offer_band_word(int unsigned band, logic [MagW-1:0] mag);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_word.band_index = BandW'(band);
    in_word.magnitude = mag;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [MagW-1:0] pick_magnitude(int unsigned shift);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return MagW'($urandom) >> shift;
    endcase
  endfunction

  task automatic offer_bands(int unsigned first, int unsigned last);
    int unsigned shift;
    shift = $urandom_range(0, 14);
    for (int unsigned b = first; b <= last; b++) offer_band_word(b, pick_magnitude(shift));
  endtask

  // Mostly whole frames in band order; the rest truncated frames and stray words.
  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned first;
    int unsigned last;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 7))
        0: begin
          first = $urandom_range(0, NumBands - 1);
          last = $urandom_range(first, NumBands - 1);
          offer_bands(first, last);
          sent += last - first + 1;
        end
        1: begin
          offer_band_word($urandom_range(0, NumBands - 1), pick_magnitude(0));
          sent++;
        end
        default: begin
          offer_bands(0, NumBands - 1);
          sent += NumBands;
        end
      endcase
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_offsets(logic [CfgDataW-1:0] data);
    write_reg(CfgOffsetBand0, data);
    write_reg(CfgOffsetBand1, data);
    write_reg(CfgOffsetBand2, data);
    write_reg(CfgOffsetBand3, data);
    write_reg(CfgOffsetOther, data);
  endtask

  // Drop valid and wait for every expected word, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: offsets hit exactly, just above, zero and full-scale words.
    offer_band_word(0, 0);
    offer_band_word(0, 100);
    offer_band_word(0, 101);
    offer_band_word(0, 32767);
    offer_band_word(1, 0);
    offer_band_word(1, 51);
    offer_band_word(1, 32767);
    offer_band_word(2, 16);
    offer_band_word(3, 32767);
    offer_band_word(4, 3);
    offer_band_word(4, 32767);
    offer_band_word(15, 32767);
    offer_band_word(14, 1234);
    offer_band_word(15, 0);
    offer_band_word(15, 0);
    run_random(200);
    drain();

    // Random registers; upper data bit exercises the 15-bit masking.
    write_reg(CfgOffsetBand0, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgOffsetBand1, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgOffsetBand2, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgOffsetBand3, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgOffsetOther, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgDecayFactor, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgPeakFloor, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CfgUnusedIndex, CfgDataW'($urandom_range(0, 65535)));
    run_random(150);
    drain();

    // No offset, slowest decay, lowest nonzero floor.
    write_offsets('0);
    write_reg(CfgDecayFactor, 16'hFFFF);
    write_reg(CfgPeakFloor, 16'd1);
    run_random(150);
    drain();

    // Largest offsets swallow every magnitude; peak drops straight to the floor.
    write_offsets(16'hFFFF);
    write_reg(CfgDecayFactor, '0);
    write_reg(CfgPeakFloor, 16'h7FFF);
    offer_band_word(0, 32767);
    offer_band_word(5, 32767);
    run_random(50);
    drain();

    // Zero floor and zero decay let the integer peak reach zero.
    write_offsets('0);
    write_reg(CfgPeakFloor, '0);
    offer_band_word(6, 0);
    offer_band_word(6, 1);
    offer_band_word(7, 0);
    run_random(60);
    drain();

    write_offsets(CfgDataW'($urandom_range(0, 200)));
    write_reg(CfgOffsetBand0, CfgDataW'($urandom_range(0, 400)));
    write_reg(CfgDecayFactor, CfgDataW'($urandom_range(50000, 65535)));
    write_reg(CfgPeakFloor, CfgDataW'($urandom_range(1, 64)));
    run_random(100);
    drain();

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
